### sv/tfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants of the triangle face normal block
// Field widths, tdata/tuser layout, status and op codes, and the sign and
// clamp helper that turns a quotient into a saturated Q1.15 component.
// ----------------------------------------------------------------------------
package tfn_pkg;

    // Field widths of one input item.
    localparam int IDX_W   = 11;
    localparam int FIELD_W = 12;

    // Input tdata layout, lowest bits first.
    localparam int IN_DATA_W = 80;
    localparam int IN_USER_W = 1;
    localparam int VI_LO = 0;
    localparam int CX_LO = 11;
    localparam int CY_LO = 23;
    localparam int CZ_LO = 35;
    localparam int CA_LO = 47;
    localparam int CB_LO = 58;
    localparam int CC_LO = 69;

    // Result layout.
    localparam int NRM_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = 48;

    // Op codes carried in the input tuser.
    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_FACE   = 1'b1;

    // Status codes carried in the output tuser.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEGEN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

    // Normalized squared length is brought into [2^60, 2^62).
    localparam int NORM_BITS  = 62;
    localparam int SHIFT_W    = 5;
    localparam int ROOT_W     = 31;
    localparam int SQRT_STEPS = 31;
    localparam int REM_W      = 34;

    // Division: quotient never exceeds 32768, so 17 quotient bits.
    localparam int Q_W     = 17;
    localparam int DNUM_W  = 48;
    localparam int SCALE_W = 32;
    localparam int DREM_W  = 32;

    typedef logic [NRM_W-1:0] t_nrm;

    // Apply the sign and clamp +1.0 to the largest positive code.
    function automatic t_nrm tfn_saturate(input logic [Q_W-1:0] q, input logic neg);
        t_nrm res;
        if (neg) begin
            res = NRM_W'(-q);
        end else if (q > Q_W'(32767)) begin
            res = 16'h7FFF;
        end else begin
            res = q[NRM_W-1:0];
        end
        return res;
    endfunction

endpackage

### sv/triangle_face_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal from a vertex store
// Vertex items fill a store; face items read three vertices, form the edge
// cross product and return it scaled to unit length in Q1.15.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                         Done when
//  s_axis    in   tuser: op; tdata: index, x, y, z, a, b, c       tvalid & tready
//  m_axis    out  tuser: status; tdata: normal x, y, z            tvalid & tready
//
//  A vertex item is written in its transfer cycle.
//  A face item runs a shift-add multiplier that retires one multiplier bit
//  per cycle (nine products), a normalizing shift of two bits per cycle, a
//  31-step square root and three 17-step divisions. A degenerate face ends
//  after the nine products; a face with a bad index goes straight to the
//  result. One face is worked at a time; the next item is taken while the
//  finished result waits on m_axis.
//  Reset is synchronous and active low; the store is not cleared.
// ----------------------------------------------------------------------------
module triangle_face_normal #(
    parameter int VERTEX_COUNT = 1024,
    parameter int COORD_BITS   = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  logic [tfn_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: op
    input  logic [tfn_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: normal_x, normal_y, normal_z
    output logic [tfn_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // tuser: status
    output logic [tfn_pkg::STATUS_W-1:0]      o_m_axis_tuser
);
    import tfn_pkg::*;

    localparam int AW    = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int CW    = COORD_BITS;
    localparam int DW    = COORD_BITS + 1;
    localparam int NW    = 2 * DW + 1;
    localparam int PW    = 2 * NW;
    localparam int ACC_W = 2 * NW + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDA   = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_RDC   = 4'd3;
    localparam logic [3:0] S_RDD   = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_MLOAD = 4'd6;
    localparam logic [3:0] S_MRUN  = 4'd7;
    localparam logic [3:0] S_MEND  = 4'd8;
    localparam logic [3:0] S_NORM  = 4'd9;
    localparam logic [3:0] S_SQRT  = 4'd10;
    localparam logic [3:0] S_DLOAD = 4'd11;
    localparam logic [3:0] S_DRUN  = 4'd12;
    localparam logic [3:0] S_DEND  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    // Control state.
    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    // Input fields.
    logic              in_op;
    logic [IDX_W-1:0]  in_vi, in_ca, in_cb, in_cc;
    logic [CW-1:0]     in_x, in_y, in_z;
    logic              s_xfer, vi_ok, face_ok, out_load;

    // Vertex store.
    logic [3*CW-1:0]   mem [VERTEX_COUNT];
    logic [3*CW-1:0]   r_rd_data;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     r_addr_a, r_addr_b, r_addr_c;

    // Datapath registers.
    logic [3*CW-1:0]        r_va, r_vb, r_vc;
    logic signed [DW-1:0]   r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic signed [NW-1:0]   r_nx, r_ny, r_nz;
    logic [3:0]             r_p;
    logic [PW-1:0]          r_mcand;
    logic [NW-1:0]          r_mplier;
    logic                   r_msub;
    logic signed [ACC_W-1:0] r_acc;
    logic [NORM_BITS-1:0]   r_s;
    logic [SHIFT_W-1:0]     r_m;
    logic [ROOT_W-1:0]      r_root;
    logic [REM_W-1:0]       r_rem;
    logic [4:0]             r_cnt;
    logic [1:0]             r_k;
    logic [DREM_W-1:0]      r_drem;
    logic [Q_W-1:0]         r_dsh;
    logic [Q_W-1:0]         r_q;
    logic                   r_dneg;
    t_nrm                   r_res [3];
    logic [STATUS_W-1:0]    r_status;
    t_nrm                   r_out_x, r_out_y, r_out_z;
    logic [STATUS_W-1:0]    r_out_st;

    // Combinational helpers.
    logic signed [NW-1:0]   opa, opb;
    logic                   opneg;
    logic [NW-1:0]          mag_a, mag_b;
    logic [REM_W-1:0]       rem_sh, trial;
    logic signed [NW-1:0]   ncur;
    logic [NW-1:0]          nmag;
    logic [SCALE_W-1:0]     nscaled;
    logic [DNUM_W-1:0]      dnum;
    logic [DREM_W:0]        dtry, dvis;

    // Unpack the slave-side transfer.
    assign in_op = i_s_axis_tuser[0];
    assign in_vi = i_s_axis_tdata[VI_LO +: IDX_W];
    assign in_x  = CW'($signed(i_s_axis_tdata[CX_LO +: FIELD_W]));
    assign in_y  = CW'($signed(i_s_axis_tdata[CY_LO +: FIELD_W]));
    assign in_z  = CW'($signed(i_s_axis_tdata[CZ_LO +: FIELD_W]));
    assign in_ca = i_s_axis_tdata[CA_LO +: IDX_W];
    assign in_cb = i_s_axis_tdata[CB_LO +: IDX_W];
    assign in_cc = i_s_axis_tdata[CC_LO +: IDX_W];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    // Index checks against the 1-based store range.
    assign vi_ok   = (in_vi != '0) && (32'(in_vi) <= 32'(VERTEX_COUNT));
    assign face_ok = (in_ca != '0) && (32'(in_ca) <= 32'(VERTEX_COUNT))
                  && (in_cb != '0) && (32'(in_cb) <= 32'(VERTEX_COUNT))
                  && (in_cc != '0) && (32'(in_cc) <= 32'(VERTEX_COUNT));

    // The result register loads when it is empty or being emptied.
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);

    // Read address follows the corner being fetched.
    always_comb begin
        unique case (r_state)
            S_RDA:   rd_addr = r_addr_a;
            S_RDB:   rd_addr = r_addr_b;
            default: rd_addr = r_addr_c;
        endcase
    end

    // Vertex store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (s_xfer && in_op == OP_VERTEX && vi_ok) begin
            mem[AW'(in_vi - IDX_W'(1))] <= {in_z, in_y, in_x};
        end
        r_rd_data <= mem[rd_addr];
    end

    // Operand schedule of the nine products: six cross terms, three squares.
    always_comb begin
        opa   = '0;
        opb   = '0;
        opneg = 1'b0;
        unique case (r_p)
            4'd0:    begin opa = NW'(r_uy); opb = NW'(r_vz); end
            4'd1:    begin opa = NW'(r_uz); opb = NW'(r_vy); opneg = 1'b1; end
            4'd2:    begin opa = NW'(r_uz); opb = NW'(r_vx); end
            4'd3:    begin opa = NW'(r_ux); opb = NW'(r_vz); opneg = 1'b1; end
            4'd4:    begin opa = NW'(r_ux); opb = NW'(r_vy); end
            4'd5:    begin opa = NW'(r_uy); opb = NW'(r_vx); opneg = 1'b1; end
            4'd6:    begin opa = r_nx; opb = r_nx; end
            4'd7:    begin opa = r_ny; opb = r_ny; end
            4'd8:    begin opa = r_nz; opb = r_nz; end
            default: begin opa = '0; opb = '0; end
        endcase
        mag_a = opa[NW-1] ? NW'(-opa) : NW'(opa);
        mag_b = opb[NW-1] ? NW'(-opb) : NW'(opb);
    end

    // Square root step: two radicand bits per cycle.
    assign rem_sh = {r_rem[REM_W-3:0], r_s[NORM_BITS-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};

    // Division setup: numerator (|n| << m) * 2^16 + r over divisor 2r.
    always_comb begin
        unique case (r_k)
            2'd0:    ncur = r_nx;
            2'd1:    ncur = r_ny;
            default: ncur = r_nz;
        endcase
        nmag    = ncur[NW-1] ? NW'(-ncur) : NW'(ncur);
        nscaled = SCALE_W'(SCALE_W'(nmag) << r_m);
        dnum    = {nscaled[DNUM_W-Q_W-1:0], 16'b0} + DNUM_W'(r_root);
    end

    assign dtry = {r_drem, r_dsh[Q_W-1]};
    assign dvis = (DREM_W + 1)'({r_root, 1'b0});

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_xfer && in_op == OP_FACE) begin
                    n_state = face_ok ? S_RDA : S_OUT;
                end
            end
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_RDC;
            S_RDC:   n_state = S_RDD;
            S_RDD:   n_state = S_DIFF;
            S_DIFF:  n_state = S_MLOAD;
            S_MLOAD: n_state = S_MRUN;
            S_MRUN:  n_state = (r_mplier == '0) ? S_MEND : S_MRUN;
            S_MEND: begin
                if (r_p != 4'd8) begin
                    n_state = S_MLOAD;
                end else if (r_acc == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM:  n_state = (r_s[NORM_BITS-1 -: 2] != 2'b00) ? S_SQRT : S_NORM;
            S_SQRT:  n_state = (r_cnt == '0) ? S_DLOAD : S_SQRT;
            S_DLOAD: n_state = S_DRUN;
            S_DRUN:  n_state = (r_cnt == '0) ? S_DEND : S_DRUN;
            S_DEND:  n_state = (r_k == 2'd2) ? S_OUT : S_DLOAD;
            S_OUT:   n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Result valid: set on load, cleared by a master-side transfer.
    always_comb begin
        n_ovalid = r_ovalid;
        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (s_xfer && in_op == OP_FACE) begin
                    r_addr_a <= AW'(in_ca - IDX_W'(1));
                    r_addr_b <= AW'(in_cb - IDX_W'(1));
                    r_addr_c <= AW'(in_cc - IDX_W'(1));
                    r_status <= face_ok ? ST_OK : ST_BAD;
                    r_res[0] <= '0;
                    r_res[1] <= '0;
                    r_res[2] <= '0;
                    r_p      <= '0;
                end
            end
            S_RDB: r_va <= r_rd_data;
            S_RDC: r_vb <= r_rd_data;
            S_RDD: r_vc <= r_rd_data;
            // Edges u = a - b and v = b - c.
            S_DIFF: begin
                r_ux <= DW'($signed(r_va[0 +: CW])) - DW'($signed(r_vb[0 +: CW]));
                r_uy <= DW'($signed(r_va[CW +: CW])) - DW'($signed(r_vb[CW +: CW]));
                r_uz <= DW'($signed(r_va[2*CW +: CW])) - DW'($signed(r_vb[2*CW +: CW]));
                r_vx <= DW'($signed(r_vb[0 +: CW])) - DW'($signed(r_vc[0 +: CW]));
                r_vy <= DW'($signed(r_vb[CW +: CW])) - DW'($signed(r_vc[CW +: CW]));
                r_vz <= DW'($signed(r_vb[2*CW +: CW])) - DW'($signed(r_vc[2*CW +: CW]));
            end
            // Load magnitudes; each cross pair and the square sum start clean.
            S_MLOAD: begin
                r_mcand  <= PW'(mag_a);
                r_mplier <= mag_b;
                r_msub   <= opa[NW-1] ^ opb[NW-1] ^ opneg;
                if (r_p == 4'd0 || r_p == 4'd2 || r_p == 4'd4 || r_p == 4'd6) begin
                    r_acc <= '0;
                end
            end
            // One multiplier bit per cycle.
            S_MRUN: begin
                if (r_mplier != '0) begin
                    if (r_mplier[0]) begin
                        r_acc <= r_msub ? r_acc - ACC_W'(r_mcand)
                                        : r_acc + ACC_W'(r_mcand);
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end
            end
            S_MEND: begin
                r_p <= r_p + 4'd1;
                if (r_p == 4'd1) r_nx <= NW'(r_acc);
                if (r_p == 4'd3) r_ny <= NW'(r_acc);
                if (r_p == 4'd5) r_nz <= NW'(r_acc);
                if (r_p == 4'd8) begin
                    r_s <= NORM_BITS'($unsigned(r_acc));
                    r_m <= '0;
                    if (r_acc == '0) begin
                        r_status <= ST_DEGEN;
                    end
                end
            end
            // Normalize by whole bit pairs so the root scales by 2^m.
            S_NORM: begin
                if (r_s[NORM_BITS-1 -: 2] == 2'b00) begin
                    r_s <= r_s << 2;
                    r_m <= r_m + SHIFT_W'(1);
                end else begin
                    r_root <= '0;
                    r_rem  <= '0;
                    r_cnt  <= 5'(SQRT_STEPS - 1);
                end
            end
            S_SQRT: begin
                r_s <= r_s << 2;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                r_k   <= '0;
            end
            S_DLOAD: begin
                r_drem <= DREM_W'(dnum[DNUM_W-1:Q_W]);
                r_dsh  <= dnum[Q_W-1:0];
                r_q    <= '0;
                r_dneg <= ncur[NW-1];
                r_cnt  <= 5'(Q_W - 1);
            end
            // Restoring division, one quotient bit per cycle.
            S_DRUN: begin
                if (dtry >= dvis) begin
                    r_drem <= DREM_W'(dtry - dvis);
                    r_q    <= {r_q[Q_W-2:0], 1'b1};
                end else begin
                    r_drem <= DREM_W'(dtry);
                    r_q    <= {r_q[Q_W-2:0], 1'b0};
                end
                r_dsh <= r_dsh << 1;
                r_cnt <= r_cnt - 5'd1;
            end
            S_DEND: begin
                r_res[r_k] <= tfn_saturate(r_q, r_dneg);
                r_k        <= r_k + 2'd1;
            end
            S_OUT: begin
                if (out_load) begin
                    r_out_x  <= r_res[0];
                    r_out_y  <= r_res[1];
                    r_out_z  <= r_res[2];
                    r_out_st <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_out_z, r_out_y, r_out_x};
    assign o_m_axis_tuser  = r_out_st;

`ifndef SYNTHESIS
    // A unit normal always has a nonzero component.
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == ST_OK) |-> (o_m_axis_tdata != '0))
        else $error("ok result with all-zero normal");

    // Degenerate and bad-index results carry zero normals.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> (o_m_axis_tdata == '0))
        else $error("error result with nonzero normal");

    // A face transfer always starts work.
    a_face_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && in_op == OP_FACE) |=> (r_state != S_IDLE))
        else $error("face transfer did not leave idle");

    // The root of a normalized radicand has its top bit set.
    a_root_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DLOAD) |-> r_root[ROOT_W-1])
        else $error("square root below normalized range");
`endif

endmodule
